/* rtl/tmssl_pkg.sv */
// Shared types, codes and helpers of the Thumb move, shift and load-store unit.
package tmssl_pkg;

  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);
  localparam int unsigned XLEN      = 32;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Highest register allowed for moves, and the first one refused by shifts and memory ops.
  localparam logic [REG_IDX_W-1:0] MOVE_REG_MAX = 4'd7;
  localparam logic [REG_IDX_W-1:0] LOW_REG_LIMIT = 4'd13;

  typedef enum logic [2:0] {
    KIND_MOV_IMM   = 3'd0,
    KIND_MOV_REG   = 3'd1,
    KIND_SHIFT_L   = 3'd2,
    KIND_SHIFT_R   = 3'd3,
    KIND_STORE     = 3'd4,
    KIND_LOAD_REQ  = 3'd5,
    KIND_LOAD_DATA = 3'd6
  } kind_e;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Flag bit positions inside the NZCV nibble.
  localparam int unsigned FLAG_N_BIT = 3;
  localparam int unsigned FLAG_Z_BIT = 2;
  localparam int unsigned FLAG_C_BIT = 1;

  typedef struct packed {
    logic [2:0]           kind;
    logic                 rejected;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rn;
    logic [REG_IDX_W-1:0] rm;
    logic [7:0]           imm;
    logic [4:0]           shamt;
    logic [1:0]           size;
    logic                 sgn;
    logic [XLEN-1:0]      load_data;
  } item_t;

  typedef struct packed {
    logic            mem_valid;
    logic            mem_is_write;
    logic [XLEN-1:0] mem_address;
    logic [XLEN-1:0] mem_wdata;
    logic [1:0]      mem_size;
    logic [3:0]      flags_nzcv;
    logic            rejected;
  } result_t;

  function automatic logic [XLEN-1:0] size_mask(input logic [1:0] size);
    logic [XLEN-1:0] m;
    case (size)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_HALF: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* rtl/tmssl_front.sv */
// Front end: unpacks an input beat, checks register limits and normalizes the access size.
module tmssl_front (
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      in_kind_i,
  input  logic [tmssl_pkg::IN_DATA_W-1:0] in_data_i,
  output logic                            q_push_o,
  input  logic                            q_ready_i,
  output tmssl_pkg::item_t                q_item_o
);
  import tmssl_pkg::*;

  logic [REG_IDX_W-1:0] rd, rn, rm;
  logic [1:0]           raw_size;
  logic                 rej;

  assign rd       = in_data_i[3:0];
  assign rn       = in_data_i[7:4];
  assign rm       = in_data_i[11:8];
  assign raw_size = in_data_i[26:25];

  always_comb begin
    rej = 1'b0;
    case (kind_e'(in_kind_i))
      KIND_MOV_IMM:  rej = (rd > MOVE_REG_MAX);
      KIND_MOV_REG:  rej = (rd > MOVE_REG_MAX) || (rm > MOVE_REG_MAX);
      KIND_SHIFT_L,
      KIND_SHIFT_R:  rej = (rd >= LOW_REG_LIMIT) || (rm >= LOW_REG_LIMIT);
      KIND_STORE,
      KIND_LOAD_REQ: rej = (rd >= LOW_REG_LIMIT);
      default:       rej = 1'b0;
    endcase
  end

  always_comb begin
    q_item_o.kind      = in_kind_i;
    q_item_o.rejected  = rej;
    q_item_o.rd        = rd;
    q_item_o.rn        = rn;
    q_item_o.rm        = rm;
    q_item_o.imm       = in_data_i[19:12];
    q_item_o.shamt     = in_data_i[24:20];
    // The unused size code is a word access.
    q_item_o.size      = (raw_size > SIZE_WORD) ? SIZE_WORD : raw_size;
    q_item_o.sgn       = in_data_i[27];
    q_item_o.load_data = in_data_i[59:28];
  end

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;

endmodule

/* rtl/tmssl_fifo.sv */
// Short queue of decoded items between the front end and the execute back end.
module tmssl_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tmssl_pkg::item_t push_item_i,
  output logic             ready_o,
  output logic             valid_o,
  output tmssl_pkg::item_t head_o,
  input  logic             pop_i
);
  import tmssl_pkg::*;

  item_t                  slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_W:0]   count_q, count_d;

  assign ready_o = (count_q != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QUEUE_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (QUEUE_PTR_W+1)'(push_i) - (QUEUE_PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/tmssl_exec.sv */
// Back end: register file read, execute, write back and the result register.
module tmssl_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  tmssl_pkg::item_t   q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tmssl_pkg::result_t out_result_o
);
  import tmssl_pkg::*;

  // Two banks of the register file so that a store can read three registers at once.
  logic [XLEN-1:0] bank_a [REG_COUNT];
  logic [XLEN-1:0] bank_b [REG_COUNT];
  logic [REG_COUNT-1:0] reg_vld_q;

  logic            x_valid_q, x_valid_d;
  item_t           x_item_q;
  logic            x_adv, retire, pop;

  logic [XLEN-1:0] rn_mem_q, rm_mem_q, rd_mem_q, fwd_data_q;
  logic            rn_vld_q, rm_vld_q, rd_vld_q;
  logic            rn_fwd_q, rm_fwd_q, rd_fwd_q;
  logic [XLEN-1:0] rn_val, rm_val, rd_val;

  logic [3:0]           flags_q;
  logic [REG_IDX_W-1:0] pend_dest_q;
  logic [1:0]           pend_size_q;
  logic                 pend_sgn_q;

  logic                 wr_en, reg_we, set_flags, carry;
  logic [REG_IDX_W-1:0] wr_idx;
  logic [XLEN-1:0]      res, masked;
  logic [XLEN:0]        lsl, lsr;
  logic [3:0]           flags_new;
  result_t              result_x;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign x_adv  = !out_valid_q || out_ready_i;
  assign retire = x_valid_q && x_adv;
  assign pop    = q_valid_i && (!x_valid_q || x_adv);
  assign q_pop_o = pop;
  assign reg_we = retire && wr_en;

  // Register file reads happen on the pop edge; a write retiring on that same edge is forwarded.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rn_mem_q   <= bank_a[q_item_i.rn];
      rm_mem_q   <= bank_a[q_item_i.rm];
      rd_mem_q   <= bank_b[q_item_i.rd];
      rn_vld_q   <= reg_vld_q[q_item_i.rn];
      rm_vld_q   <= reg_vld_q[q_item_i.rm];
      rd_vld_q   <= reg_vld_q[q_item_i.rd];
      rn_fwd_q   <= reg_we && (wr_idx == q_item_i.rn);
      rm_fwd_q   <= reg_we && (wr_idx == q_item_i.rm);
      rd_fwd_q   <= reg_we && (wr_idx == q_item_i.rd);
      fwd_data_q <= res;
      x_item_q   <= q_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      bank_a[wr_idx] <= res;
      bank_b[wr_idx] <= res;
    end
  end

  // An entry that was never written since reset reads as zero.
  assign rn_val = rn_fwd_q ? fwd_data_q : (rn_vld_q ? rn_mem_q : '0);
  assign rm_val = rm_fwd_q ? fwd_data_q : (rm_vld_q ? rm_mem_q : '0);
  assign rd_val = rd_fwd_q ? fwd_data_q : (rd_vld_q ? rd_mem_q : '0);

  assign lsl    = {1'b0, rm_val} << x_item_q.shamt;
  assign lsr    = {rm_val, 1'b0} >> x_item_q.shamt;
  assign masked = x_item_q.load_data & size_mask(pend_size_q);

  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = x_item_q.rd;
    res       = '0;
    set_flags = 1'b0;
    carry     = 1'b0;
    result_x  = '0;
    if (!x_item_q.rejected) begin
      case (kind_e'(x_item_q.kind))
        KIND_MOV_IMM: begin
          res       = {{(XLEN-8){1'b0}}, x_item_q.imm};
          wr_en     = 1'b1;
          set_flags = 1'b1;
        end
        KIND_MOV_REG: begin
          res       = rm_val;
          wr_en     = 1'b1;
          set_flags = 1'b1;
        end
        KIND_SHIFT_L: begin
          res       = lsl[XLEN-1:0];
          carry     = (x_item_q.shamt == '0) ? flags_q[FLAG_C_BIT] : lsl[XLEN];
          wr_en     = 1'b1;
          set_flags = 1'b1;
        end
        KIND_SHIFT_R: begin
          // A zero count encodes a shift by the full word.
          res       = (x_item_q.shamt == '0) ? '0 : lsr[XLEN:1];
          carry     = (x_item_q.shamt == '0) ? rm_val[XLEN-1] : lsr[0];
          wr_en     = 1'b1;
          set_flags = 1'b1;
        end
        KIND_STORE: begin
          result_x.mem_valid    = 1'b1;
          result_x.mem_is_write = 1'b1;
          result_x.mem_address  = rn_val + rm_val;
          result_x.mem_wdata    = rd_val & size_mask(x_item_q.size);
          result_x.mem_size     = x_item_q.size;
        end
        KIND_LOAD_REQ: begin
          result_x.mem_valid   = 1'b1;
          result_x.mem_address = rn_val + rm_val;
          result_x.mem_size    = x_item_q.size;
        end
        KIND_LOAD_DATA: begin
          wr_en  = 1'b1;
          wr_idx = pend_dest_q;
          res    = masked;
          if (pend_sgn_q && (pend_size_q == SIZE_BYTE) && masked[7]) begin
            res = masked | 32'hFFFF_FF00;
          end else if (pend_sgn_q && (pend_size_q == SIZE_HALF) && masked[15]) begin
            res = masked | 32'hFFFF_0000;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    flags_new = set_flags ? {res[XLEN-1], (res == '0), carry, 1'b0} : flags_q;
    result_x.flags_nzcv = flags_new;
    result_x.rejected   = x_item_q.rejected;
  end

  always_comb begin
    x_valid_d = x_valid_q;
    if (pop) begin
      x_valid_d = 1'b1;
    end else if (retire) begin
      x_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (retire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      reg_vld_q   <= '0;
      flags_q     <= '0;
      pend_dest_q <= '0;
      pend_size_q <= SIZE_BYTE;
      pend_sgn_q  <= 1'b0;
    end else begin
      x_valid_q   <= x_valid_d;
      out_valid_q <= out_valid_d;
      if (reg_we) begin
        reg_vld_q[wr_idx] <= 1'b1;
      end
      if (retire) begin
        flags_q <= flags_new;
      end
      if (retire && !x_item_q.rejected && (kind_e'(x_item_q.kind) == KIND_LOAD_REQ)) begin
        pend_dest_q <= x_item_q.rd;
        pend_size_q <= x_item_q.size;
        pend_sgn_q  <= x_item_q.sgn;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      out_q <= result_x;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  a_no_write_when_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reg_we |-> !x_item_q.rejected)
    else $error("register write from a rejected item");

  a_write_index_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reg_we && (kind_e'(x_item_q.kind) != KIND_LOAD_DATA) |-> (wr_idx < LOW_REG_LIMIT))
    else $error("register write outside the allowed range");

  a_idle_request_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.mem_valid |-> !out_q.mem_is_write && (out_q.mem_address == '0)
      && (out_q.mem_wdata == '0) && (out_q.mem_size == '0))
    else $error("memory fields set without a request");

  a_rejected_no_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rejected |-> !out_q.mem_valid)
    else $error("rejected item issued a memory request");

  a_flags_kept_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire && x_item_q.rejected |=> $stable(flags_q))
    else $error("flags changed by a rejected item");

endmodule

/* rtl/thumb_move_shift_load_store_unit_core.sv */
// A beat is registered in the queue, the execute stage and the result register in turn.
// Throughput: one beat per cycle unless the output stalls, set by the registered read of
// the two register file banks, a combinational execute stage and a forwarded write.
// A four-entry queue decouples the input from the execute stage and its result register.
// Reset clears the register file valid bits (registers read as zero), the flags,
// the pending load state, the queue and all pipeline valid bits; no clearing pass.
module thumb_move_shift_load_store_unit_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // kind
  input  logic [2:0]                       s_axis_tuser_i,
  // dest_index, base_index, source_index, imm_value, shift_amount, access_size,
  // sign_extend, load_data
  input  logic [tmssl_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // mem_valid, mem_is_write, mem_address, mem_wdata, mem_size, flags_nzcv, rejected
  output logic [tmssl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import tmssl_pkg::*;

  logic    q_push, q_ready, q_valid, q_pop;
  item_t   push_item, head_item;
  result_t result;

  tmssl_front u_front (
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_kind_i  (s_axis_tuser_i),
    .in_data_i  (s_axis_tdata_i),
    .q_push_o   (q_push),
    .q_ready_i  (q_ready),
    .q_item_o   (push_item)
  );

  tmssl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .head_o      (head_item),
    .pop_i       (q_pop)
  );

  tmssl_exec u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (head_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_result_o (result)
  );

  assign m_axis_tdata_o = {7'b0, result.rejected, result.flags_nzcv, result.mem_size,
                           result.mem_wdata, result.mem_address, result.mem_is_write,
                           result.mem_valid};

endmodule

/* verif/tb_thumb_move_shift_load_store_unit_core.sv */
// Self-checking testbench for the Thumb move, shift and load-store unit core.
module tb_thumb_move_shift_load_store_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tmssl_pkg::*;

  localparam logic [2:0] KIND_NOP = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_LIMIT = 4000;
  localparam int unsigned RANDOM_CHUNKS = 17;
  localparam int unsigned CHUNK_ITEMS = 100;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  rd;
    logic [3:0]  rn;
    logic [3:0]  rm;
    logic [7:0]  imm;
    logic [4:0]  shamt;
    logic [1:0]  size;
    logic        sgn;
    logic [31:0] ldata;
  } thumb_op_t;

  typedef struct {
    logic        valid;
    logic        is_wr;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [1:0]  msize;
    logic [3:0]  nzcv;
    logic        rej;
  } mem_flags_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // kind
  logic [2:0]  s_axis_tuser_i;
  // dest_index, base_index, source_index, imm_value, shift_amount, access_size,
  // sign_extend, load_data
  logic [63:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // mem_valid, mem_is_write, mem_address, mem_wdata, mem_size, flags_nzcv, rejected
  logic [79:0] m_axis_tdata_o;

  thumb_move_shift_load_store_unit_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Shadow architectural state of the core.
  logic [31:0] shadow_regs [REG_COUNT];
  logic [3:0]  shadow_flags;
  logic [3:0]  shadow_load_dest;
  logic [1:0]  shadow_load_size;
  logic        shadow_load_sgn;

  mem_flags_t predicted_results[$];

  int unsigned mismatches = 0;
  int unsigned missing_results = 0;
  int unsigned beats_sent = 0;
  int unsigned results_checked = 0;
  int unsigned rejects_seen = 0;
  int unsigned load_returns = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold = 0;
  bit          sender_steady;
  bit          receiver_steady;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic thumb_op_t make_op(logic [2:0] kind, logic [3:0] rd, logic [3:0] rn,
                                        logic [3:0] rm, logic [7:0] imm, logic [4:0] shamt,
                                        logic [1:0] size, logic sgn, logic [31:0] ldata);
    thumb_op_t op;
    op.kind = kind;
    op.rd = rd;
    op.rn = rn;
    op.rm = rm;
    op.imm = imm;
    op.shamt = shamt;
    op.size = size;
    op.sgn = sgn;
    op.ldata = ldata;
    return op;
  endfunction

  function automatic logic [63:0] pack_op(thumb_op_t op);
    return {4'b0, op.ldata, op.sgn, op.size, op.shamt, op.imm, op.rm, op.rn, op.rd};
  endfunction

  function automatic mem_flags_t unpack_result(logic [79:0] d);
    mem_flags_t r;
    r.valid = d[0];
    r.is_wr = d[1];
    r.addr  = d[33:2];
    r.wdata = d[65:34];
    r.msize = d[67:66];
    r.nzcv  = d[71:68];
    r.rej   = d[72];
    return r;
  endfunction

  function automatic logic [31:0] access_mask(logic [1:0] size);
    logic [31:0] m;
    case (size)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_HALF: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] nzcv_of(logic [31:0] res, logic carry);
    logic [3:0] f;
    f = '0;
    f[FLAG_N_BIT] = res[31];
    f[FLAG_Z_BIT] = (res == '0);
    f[FLAG_C_BIT] = carry;
    return f;
  endfunction

  // Executes one operation on the shadow state and queues the result it must produce.
  task automatic exec_thumb_op(input thumb_op_t op);
    mem_flags_t  r;
    logic [1:0]  size;
    logic [31:0] src;
    logic [31:0] res;
    logic        carry;
    r = '{default: '0};
    size = (op.size == 2'd3) ? SIZE_WORD : op.size;
    case (op.kind)
      KIND_MOV_IMM: begin
        if (op.rd > MOVE_REG_MAX) begin
          r.rej = 1'b1;
        end else begin
          shadow_regs[op.rd] = {24'b0, op.imm};
          shadow_flags = nzcv_of({24'b0, op.imm}, 1'b0);
        end
      end
      KIND_MOV_REG: begin
        if (op.rd > MOVE_REG_MAX || op.rm > MOVE_REG_MAX) begin
          r.rej = 1'b1;
        end else begin
          res = shadow_regs[op.rm];
          shadow_regs[op.rd] = res;
          shadow_flags = nzcv_of(res, 1'b0);
        end
      end
      KIND_SHIFT_L, KIND_SHIFT_R: begin
        if (op.rd >= LOW_REG_LIMIT || op.rm >= LOW_REG_LIMIT) begin
          r.rej = 1'b1;
        end else begin
          src = shadow_regs[op.rm];
          if (op.kind == KIND_SHIFT_L) begin
            if (op.shamt == '0) begin
              res = src;
              carry = shadow_flags[FLAG_C_BIT];
            end else begin
              carry = src[32 - int'(op.shamt)];
              res = src << op.shamt;
            end
          end else begin
            // A right shift by zero encodes a shift by 32.
            if (op.shamt == '0) begin
              carry = src[31];
              res = '0;
            end else begin
              carry = src[int'(op.shamt) - 1];
              res = src >> op.shamt;
            end
          end
          shadow_regs[op.rd] = res;
          shadow_flags = nzcv_of(res, carry);
        end
      end
      KIND_STORE: begin
        if (op.rd >= LOW_REG_LIMIT) begin
          r.rej = 1'b1;
        end else begin
          r.valid = 1'b1;
          r.is_wr = 1'b1;
          r.addr = shadow_regs[op.rn] + shadow_regs[op.rm];
          r.wdata = shadow_regs[op.rd] & access_mask(size);
          r.msize = size;
        end
      end
      KIND_LOAD_REQ: begin
        if (op.rd >= LOW_REG_LIMIT) begin
          r.rej = 1'b1;
        end else begin
          r.valid = 1'b1;
          r.addr = shadow_regs[op.rn] + shadow_regs[op.rm];
          r.msize = size;
          shadow_load_dest = op.rd;
          shadow_load_size = size;
          shadow_load_sgn = op.sgn;
        end
      end
      KIND_LOAD_DATA: begin
        res = op.ldata & access_mask(shadow_load_size);
        if (shadow_load_sgn) begin
          if (shadow_load_size == SIZE_BYTE && res[7]) res[31:8] = '1;
          else if (shadow_load_size == SIZE_HALF && res[15]) res[31:16] = '1;
        end
        shadow_regs[shadow_load_dest] = res;
        load_returns++;
      end
      default: begin
      end
    endcase
    r.nzcv = shadow_flags;
    if (r.rej) rejects_seen++;
    predicted_results.push_back(r);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_op(input thumb_op_t op);
    int unsigned gap;
    gap = (sender_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op.kind;
    s_axis_tdata_i  <= pack_op(op);
    do @(posedge clk_i); while (!s_axis_tready_o);
    exec_thumb_op(op);
    beats_sent++;
  endtask

  // Load data arriving before any request uses the reset defaults.
  task automatic test_load_without_request();
    send_op(make_op(KIND_LOAD_DATA, 4'd9, 4'd0, 4'd0, 8'd0, 5'd0, SIZE_WORD, 1'b1,
                    32'hFFFF_FFFF));
    send_op(make_op(KIND_NOP, 4'd15, 4'd15, 4'd15, 8'hFF, 5'd31, 2'd3, 1'b1,
                    32'hFFFF_FFFF));
  endtask

  task automatic test_moves();
    send_op(make_op(KIND_MOV_IMM, 4'd0, 4'd0, 4'd0, 8'hFF, 5'd0, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_MOV_IMM, 4'd7, 4'd0, 4'd0, 8'h00, 5'd0, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_MOV_IMM, 4'd8, 4'd0, 4'd0, 8'h55, 5'd0, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_MOV_REG, 4'd1, 4'd0, 4'd0, 8'h00, 5'd0, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_MOV_REG, 4'd1, 4'd0, 4'd8, 8'h00, 5'd0, SIZE_BYTE, 1'b0, '0));
  endtask

  task automatic test_shifts();
    send_op(make_op(KIND_SHIFT_L, 4'd2, 4'd0, 4'd0, 8'h00, 5'd24, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_SHIFT_L, 4'd3, 4'd0, 4'd2, 8'h00, 5'd1, SIZE_BYTE, 1'b0, '0));
    // A left shift by zero must keep the carry set just above.
    send_op(make_op(KIND_SHIFT_L, 4'd4, 4'd0, 4'd3, 8'h00, 5'd0, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_SHIFT_R, 4'd5, 4'd0, 4'd2, 8'h00, 5'd0, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_SHIFT_R, 4'd12, 4'd0, 4'd2, 8'h00, 5'd31, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_SHIFT_L, 4'd12, 4'd0, 4'd12, 8'h00, 5'd31, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_SHIFT_R, 4'd13, 4'd0, 4'd2, 8'h00, 5'd4, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_SHIFT_L, 4'd2, 4'd0, 4'd15, 8'h00, 5'd4, SIZE_BYTE, 1'b0, '0));
  endtask

  task automatic test_stores();
    send_op(make_op(KIND_STORE, 4'd2, 4'd15, 4'd0, 8'h00, 5'd0, SIZE_BYTE, 1'b0, '0));
    send_op(make_op(KIND_STORE, 4'd3, 4'd2, 4'd3, 8'h00, 5'd0, SIZE_HALF, 1'b0, '0));
    send_op(make_op(KIND_STORE, 4'd2, 4'd2, 4'd2, 8'h00, 5'd0, 2'd3, 1'b0, '0));
    send_op(make_op(KIND_STORE, 4'd13, 4'd0, 4'd0, 8'h00, 5'd0, SIZE_WORD, 1'b0, '0));
  endtask

  task automatic test_loads();
    send_op(make_op(KIND_LOAD_REQ, 4'd6, 4'd0, 4'd2, 8'h00, 5'd0, SIZE_BYTE, 1'b1, '0));
    send_op(make_op(KIND_LOAD_DATA, 4'd0, 4'd0, 4'd0, 8'h00, 5'd0, SIZE_WORD, 1'b0,
                    32'hFFFF_FF80));
    send_op(make_op(KIND_LOAD_REQ, 4'd7, 4'd14, 4'd15, 8'h00, 5'd0, SIZE_HALF, 1'b1, '0));
    send_op(make_op(KIND_LOAD_DATA, 4'd0, 4'd0, 4'd0, 8'h00, 5'd0, SIZE_BYTE, 1'b0,
                    32'h1234_8000));
    // Sign extension has no effect on a word, and size three acts as a word.
    send_op(make_op(KIND_LOAD_REQ, 4'd8, 4'd2, 4'd2, 8'h00, 5'd0, 2'd3, 1'b1, '0));
    send_op(make_op(KIND_LOAD_DATA, 4'd0, 4'd0, 4'd0, 8'h00, 5'd0, SIZE_BYTE, 1'b1,
                    32'h8000_0001));
    send_op(make_op(KIND_LOAD_DATA, 4'd0, 4'd0, 4'd0, 8'h00, 5'd0, SIZE_BYTE, 1'b0,
                    32'h0000_0055));
    send_op(make_op(KIND_LOAD_REQ, 4'd13, 4'd0, 4'd0, 8'h00, 5'd0, SIZE_BYTE, 1'b0, '0));
  endtask

  function automatic thumb_op_t random_op(logic [2:0] kind);
    thumb_op_t op;
    op = make_op(kind, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), $urandom());
    if ($urandom_range(0, 4) == 0) op.shamt = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'd31;
    // Most operations stay within the register limits so that state keeps evolving.
    if ($urandom_range(0, 9) < 8) begin
      if (kind == KIND_MOV_IMM || kind == KIND_MOV_REG) begin
        op.rd = 4'($urandom_range(0, 7));
        op.rm = 4'($urandom_range(0, 7));
      end else begin
        op.rd = 4'($urandom_range(0, 12));
        op.rm = 4'($urandom_range(0, 12));
      end
    end
    return op;
  endfunction

  task automatic test_random();
    int unsigned sent;
    thumb_op_t   op;
    for (int unsigned c = 0; c < RANDOM_CHUNKS; c++) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < CHUNK_ITEMS) begin
        if ($urandom_range(0, 99) < 18) begin
          op = random_op(KIND_LOAD_REQ);
          if ($urandom_range(0, 9) != 0) op.rd = 4'($urandom_range(0, 12));
          send_op(op);
          sent++;
          if ($urandom_range(0, 9) == 0) begin
            send_op(random_op(kind_e'($urandom_range(0, 4))));
            sent++;
          end
          send_op(random_op(KIND_LOAD_DATA));
          sent++;
        end else begin
          if ($urandom_range(0, 39) == 0) op = random_op(KIND_NOP);
          else op = random_op(3'($urandom_range(0, 6)));
          send_op(op);
          sent++;
        end
      end
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    for (int unsigned i = 0; i < DRAIN_LIMIT && predicted_results.size() != 0; i++)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    missing_results = predicted_results.size();
    if (missing_results != 0) begin
      $display("%0t: %0d expected results never arrived", $time, missing_results);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Output beats are compared with the oldest predicted result.
  always @(posedge clk_i) begin
    mem_flags_t got;
    mem_flags_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = unpack_result(m_axis_tdata_o);
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time,
                 m_axis_tdata_o);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        check_field("mem_valid", 32'(want.valid), 32'(got.valid));
        check_field("mem_is_write", 32'(want.is_wr), 32'(got.is_wr));
        check_field("mem_address", want.addr, got.addr);
        check_field("mem_wdata", want.wdata, got.wdata);
        check_field("mem_size", 32'(want.msize), 32'(got.msize));
        check_field("flags_nzcv", 32'(want.nzcv), 32'(got.nzcv));
        check_field("rejected", 32'(want.rej), 32'(got.rej));
        results_checked++;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!receiver_steady && $urandom_range(0, 3) == 0) begin
      rx_hold <= pick_gap() - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i = '0;
    s_axis_tdata_i = '0;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    shadow_flags = '0;
    shadow_load_dest = '0;
    shadow_load_size = SIZE_BYTE;
    shadow_load_sgn = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_load_without_request();
    test_moves();
    test_shifts();
    test_stores();
    test_loads();
    test_random();
    wait_drain();

    $display("Sent %0d operations and checked %0d results, %0d of them rejected,",
             beats_sent, results_checked, rejects_seen);
    $display("with %0d load data returns, under random stalls on both sides.", load_returns);
    if (mismatches == 0 && missing_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
